@@ hw/rtl/chkv_pkg.sv @@
// shared constants for the chained hash key/value table
package chkv_pkg;

  // request codes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  // field widths
  localparam int OP_W    = 2;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 64;
  localparam int COUNT_W = 9;

  // stream beat widths, padded to whole bytes
  localparam int IN_W  = 104;
  localparam int OUT_W = 80;

  // fibonacci hash multiplier and fold distance
  localparam logic [KEY_W-1:0] HASH_MULT  = 32'h61C88647;
  localparam int               HASH_FOLD  = 16;

  // status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NOSPACE = 1'b1;

endpackage

@@ hw/rtl/chkv_hash.sv @@
// bucket hash: registered multiply, then xor fold and mask
module chkv_hash #(
  parameter int BUCKET_BITS = 8
) (
  input  logic                      clk,
  input  logic                      load,
  input  logic [chkv_pkg::KEY_W-1:0] key,
  output logic [BUCKET_BITS-1:0]    bucket
);
  import chkv_pkg::*;

  logic [KEY_W-1:0] prod;

  // low word of key times multiplier
  always_ff @(posedge clk) begin
    if (load) begin
      prod <= key * HASH_MULT;
    end
  end

  // fold high half into low bits
  assign bucket = prod[BUCKET_BITS-1:0] ^ prod[HASH_FOLD +: BUCKET_BITS];

endmodule

@@ hw/rtl/chained_hash_key_value_table.sv @@
// top level: request sequencer over bucket head, entry and free stack memories
// flow: an accepted beat passes HASH, HEAD, WALK for each chain entry visited, ACT, ALLOC for
// an insert that takes a new entry, and DONE; an unused op code goes from HASH straight to DONE
// requests: one request at a time, the next beat is taken only once the result is issued and
// the sequencer is back in idle; the chain walk sets the rate
// reset: a clearing pass empties every bucket head and refills the free stack
module chained_hash_key_value_table #(
  parameter int BUCKET_BITS  = 8,
  parameter int POOL_ENTRIES = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [chkv_pkg::IN_W-1:0]    s_tdata,  // op, key, data
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [chkv_pkg::OUT_W-1:0]   m_tdata   // found, value, status, entry_count
);
  import chkv_pkg::*;

  localparam int NB      = 2 ** BUCKET_BITS;
  localparam int IW      = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int CW      = $clog2(POOL_ENTRIES + 1);
  localparam int CLR_LEN = (NB > POOL_ENTRIES) ? NB : POOL_ENTRIES;
  localparam int CLRW    = $clog2(CLR_LEN);
  localparam logic [CW-1:0] POOL_C = CW'(POOL_ENTRIES);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HASH  = 3'd2;
  localparam logic [2:0] ST_HEAD  = 3'd3;
  localparam logic [2:0] ST_WALK  = 3'd4;
  localparam logic [2:0] ST_ACT   = 3'd5;
  localparam logic [2:0] ST_ALLOC = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CW-1:0]    link;
    logic [VAL_W-1:0] value;
  } entry_t;

  logic [2:0]             state;
  logic [CLRW-1:0]        clr;
  logic [CW-1:0]          held;
  logic [OP_W-1:0]        req_op;
  logic [KEY_W-1:0]       req_key;
  logic [VAL_W-1:0]       req_data;
  logic [BUCKET_BITS-1:0] bucket;
  logic [BUCKET_BITS-1:0] bucket_q;
  logic [CW-1:0]          head_code;
  logic [CW-1:0]          cur;
  logic [CW-1:0]          prev;
  entry_t                 cur_word;
  entry_t                 prev_word;
  logic                   hit;

  logic                   res_found;
  logic [VAL_W-1:0]       res_value;
  logic                   res_status;

  // memories
  logic [CW-1:0]  head_mem [NB];
  entry_t         entry_mem [POOL_ENTRIES];
  logic [IW-1:0]  free_mem [POOL_ENTRIES];

  logic [CW-1:0]          head_q;
  entry_t                 entry_q;
  logic [IW-1:0]          free_q;

  logic                   head_re, head_we;
  logic [BUCKET_BITS-1:0] head_ra, head_wa;
  logic [CW-1:0]          head_wd;
  logic                   entry_re, entry_we;
  logic [IW-1:0]          entry_ra, entry_wa;
  entry_t                 entry_wd;
  logic                   free_re, free_we;
  logic [IW-1:0]          free_ra, free_wa;
  logic [IW-1:0]          free_wd;

  logic accept;
  logic key_match;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign key_match = (entry_q.key == req_key);

  chkv_hash #(.BUCKET_BITS(BUCKET_BITS)) u_hash (
    .clk    (clk),
    .load   (accept),
    .key    (s_tdata[OP_W +: KEY_W]),
    .bucket (bucket)
  );

  // memory port control
  always_comb begin
    head_re  = 1'b0;
    head_ra  = bucket;
    head_we  = 1'b0;
    head_wa  = bucket_q;
    head_wd  = '0;
    entry_re = 1'b0;
    entry_ra = IW'(entry_q.link - 1'b1);
    entry_we = 1'b0;
    entry_wa = IW'(cur - 1'b1);
    entry_wd = cur_word;
    free_re  = 1'b0;
    free_ra  = IW'(POOL_C - held - 1'b1);
    free_we  = 1'b0;
    free_wa  = IW'(POOL_C - held);
    free_wd  = IW'(cur - 1'b1);
    unique case (state)
      ST_CLEAR: begin
        head_we = (CLRW'(clr) < CLRW'(NB - 1)) || (CLRW'(clr) == CLRW'(NB - 1));
        head_wa = BUCKET_BITS'(clr);
        free_we = (32'(clr) < POOL_ENTRIES);
        free_wa = IW'(clr);
        free_wd = IW'(clr);
      end
      ST_HASH: begin
        head_re = 1'b1;
      end
      ST_HEAD: begin
        entry_re = (head_q != '0);
        entry_ra = IW'(head_q - 1'b1);
      end
      ST_WALK: begin
        entry_re = !key_match && (entry_q.link != '0);
      end
      ST_ACT: begin
        if (hit && req_op == OP_INSERT) begin
          entry_we       = 1'b1;
          entry_wd.value = req_data;
        end else if (hit && req_op == OP_DELETE) begin
          if (prev == '0) begin
            head_we = 1'b1;
            head_wd = cur_word.link;
          end else begin
            entry_we      = 1'b1;
            entry_wa      = IW'(prev - 1'b1);
            entry_wd      = prev_word;
            entry_wd.link = cur_word.link;
          end
          free_we = 1'b1;
        end else if (!hit && req_op == OP_INSERT && held < POOL_C) begin
          free_re = 1'b1;
        end
      end
      ST_ALLOC: begin
        entry_we       = 1'b1;
        entry_wa       = free_q;
        entry_wd.key   = req_key;
        entry_wd.link  = head_code;
        entry_wd.value = req_data;
        head_we        = 1'b1;
        head_wd        = CW'(free_q) + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // bucket head memory
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    if (head_re) begin
      head_q <= head_mem[head_ra];
    end
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (entry_we) begin
      entry_mem[entry_wa] <= entry_wd;
    end
    if (entry_re) begin
      entry_q <= entry_mem[entry_ra];
    end
  end

  // free stack memory
  always_ff @(posedge clk) begin
    if (free_we) begin
      free_mem[free_wa] <= free_wd;
    end
    if (free_re) begin
      free_q <= free_mem[free_ra];
    end
  end

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr      <= '0;
      held     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == CLRW'(CLR_LEN - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_HASH;
          end
        end
        ST_HASH: begin
          state <= (req_op == OP_LOOKUP || req_op == OP_INSERT || req_op == OP_DELETE)
                   ? ST_HEAD : ST_DONE;
        end
        ST_HEAD: begin
          state <= (head_q != '0) ? ST_WALK : ST_ACT;
        end
        ST_WALK: begin
          if (key_match || entry_q.link == '0) begin
            state <= ST_ACT;
          end
        end
        ST_ACT: begin
          if (hit && req_op == OP_DELETE) begin
            held <= held - 1'b1;
          end
          state <= free_re ? ST_ALLOC : ST_DONE;
        end
        ST_ALLOC: begin
          held  <= held + 1'b1;
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // request payload, walk position and result fields
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        req_op     <= s_tdata[0 +: OP_W];
        req_key    <= s_tdata[OP_W +: KEY_W];
        req_data   <= s_tdata[OP_W + KEY_W +: VAL_W];
        res_found  <= 1'b0;
        res_value  <= '0;
        res_status <= STATUS_OK;
        hit        <= 1'b0;
      end
      ST_HASH: begin
        bucket_q <= bucket;
        prev     <= '0;
      end
      ST_HEAD: begin
        head_code <= head_q;
        cur       <= head_q;
      end
      ST_WALK: begin
        if (key_match) begin
          hit      <= 1'b1;
          cur_word <= entry_q;
        end else begin
          prev      <= cur;
          prev_word <= entry_q;
          cur       <= entry_q.link;
        end
      end
      ST_ACT: begin
        res_found <= hit;
        if (hit && req_op == OP_LOOKUP) begin
          res_value <= cur_word.value;
        end
        if (!hit && req_op == OP_INSERT && held == POOL_C) begin
          res_status <= STATUS_NOSPACE;
        end
      end
      default: begin
      end
    endcase
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {5'd0, COUNT_W'(held), res_status, res_value, res_found};
    end
  end

endmodule
